@@ rtl/core/ipv6_fragment_planner_top_assert.svh @@
// ----------------------------------------------------------------------------
// IPv6 fragment planner assertion macros
// Shared concurrent assertion forms for the fragment planner RTL.
// ----------------------------------------------------------------------------
`ifndef IPV6_FRAGMENT_PLANNER_TOP_ASSERT_SVH
`define IPV6_FRAGMENT_PLANNER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPV6FP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPV6FP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ipv6fp_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv6 fragment planner package
// Types and constants shared by the fragment planner RTL.
// ----------------------------------------------------------------------------
package ipv6fp_pkg;

  // Header sizes in bytes: IPv6 base header and IPv6 plus fragment header.
  localparam logic [15:0] IPV6_HDR_LEN  = 16'd40;
  localparam logic [15:0] FRAG_HDR_LEN  = 16'd48;
  // Smallest MTU the planner will ever use.
  localparam logic [15:0] FLOOR_MTU     = 16'd1280;
  // Reset value of the MTU register.
  localparam logic [15:0] MTU_RESET     = 16'd1280;
  // Mask that rounds a size down to a multiple of eight bytes.
  localparam logic [15:0] ALIGN_MASK    = 16'hFFF8;
  // Difference between the IPv6 MTU and the MTU reported to IPv4 senders.
  localparam logic [15:0] ICMP_MTU_ADJ  = 16'd20;

  // Kind of one planned output piece.
  typedef enum logic [1:0] {
    KIND_WHOLE = 2'd0,
    KIND_FRAG  = 2'd1,
    KIND_DROP  = 2'd2
  } piece_kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SPLIT
  } state_t;

endpackage

@@ rtl/core/ipv6_fragment_planner_top.sv @@
// A request is captured in ST_IDLE; its first result is registered from ST_PLAN once the output is free.
// Throughput: one result per cycle while splitting and the output is not stalled; no new request is
// taken until the last piece of a packet is loaded (at most 54 pieces).
// The rate is set by the single remainder/compare unit that sizes one piece per step.
// Reset (rst_n, synchronous, active low) empties the sequencer and output; the MTU reads 1280.
// ----------------------------------------------------------------------------
// IPv6 fragment planner
// Plans the pieces of a translated IPv6 packet: pass whole, drop with an ICMP
// fragmentation-needed MTU, or split to the aligned effective MTU one piece a step.
// ----------------------------------------------------------------------------
module ipv6_fragment_planner_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Input request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_packet_len,
  input  logic        in_from_ipv4,
  input  logic        in_dont_fragment,
  input  logic [15:0] in_offset_in,
  input  logic        in_more_in,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_piece_kind,
  output logic [15:0] out_piece_total_len,
  output logic [15:0] out_data_start,
  output logic [15:0] out_offset_out,
  output logic        out_more_out,
  output logic [15:0] out_ipv6_payload_len,
  output logic [15:0] out_icmp_mtu,
  output logic        out_last
);

  `include "ipv6_fragment_planner_top_assert.svh"

  ipv6fp_pkg::state_t state_r, state_nxt;

  logic [15:0] mtu_cfg_r;
  logic [15:0] len_r;
  logic        v4_r;
  logic        df_r;
  logic [15:0] off_r;
  logic        mf_r;
  logic [15:0] m_r, m_nxt;
  logic [15:0] pos_r, pos_nxt;

  logic                    out_valid_r, out_valid_nxt;
  ipv6fp_pkg::piece_kind_t kind_r, kind_nxt;
  logic [15:0]             total_r, total_nxt;
  logic [15:0]             start_r, start_nxt;
  logic [15:0]             offo_r, offo_nxt;
  logic                    moreo_r, moreo_nxt;
  logic [15:0]             plen_r, plen_nxt;
  logic [15:0]             icmp_r, icmp_nxt;
  logic                    last_r, last_nxt;

  logic        in_acc;
  logic        out_free;
  logic        load;
  logic [15:0] mtu_eff;
  logic [15:0] m_plan;
  logic [15:0] pmax;
  logic [15:0] rem;
  logic        fin;
  logic [15:0] sz;
  logic [15:0] tot;

  // The configuration register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_cfg_r <= ipv6fp_pkg::MTU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mtu_cfg_r <= cfg_data;
    end
  end

  // Handshake terms.
  assign in_stall = (state_r != ipv6fp_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Effective MTU never drops below the IPv6 minimum.
  assign mtu_eff = (mtu_cfg_r < ipv6fp_pkg::FLOOR_MTU) ? ipv6fp_pkg::FLOOR_MTU : mtu_cfg_r;
  assign m_plan  = mtu_eff & ipv6fp_pkg::ALIGN_MASK;

  // Piece-sizing unit for the later pieces: remaining bytes against the largest payload.
  assign pmax = m_r - ipv6fp_pkg::FRAG_HDR_LEN;
  assign rem  = len_r - pos_r;
  assign fin  = (rem <= pmax);
  assign sz   = fin ? rem : pmax;
  assign tot  = ipv6fp_pkg::FRAG_HDR_LEN + sz;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r <= in_packet_len;
      v4_r  <= in_from_ipv4;
      df_r  <= in_dont_fragment;
      off_r <= in_offset_in;
      mf_r  <= in_more_in;
    end
  end

  // Sequencer and result selection.
  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    pos_nxt   = pos_r;
    load      = 1'b0;
    kind_nxt  = kind_r;
    total_nxt = total_r;
    start_nxt = start_r;
    offo_nxt  = offo_r;
    moreo_nxt = moreo_r;
    plen_nxt  = plen_r;
    icmp_nxt  = icmp_r;
    last_nxt  = last_r;
    unique case (state_r)
      ipv6fp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ipv6fp_pkg::ST_PLAN;
        end
      end
      ipv6fp_pkg::ST_PLAN: begin
        if (out_free) begin
          load = 1'b1;
          if (!v4_r || (len_r <= mtu_eff)) begin
            // Packet passes whole.
            kind_nxt  = ipv6fp_pkg::KIND_WHOLE;
            total_nxt = len_r;
            start_nxt = '0;
            offo_nxt  = off_r;
            moreo_nxt = mf_r;
            plen_nxt  = (len_r >= ipv6fp_pkg::IPV6_HDR_LEN) ?
                        (len_r - ipv6fp_pkg::IPV6_HDR_LEN) : '0;
            icmp_nxt  = '0;
            last_nxt  = 1'b1;
            state_nxt = ipv6fp_pkg::ST_IDLE;
          end else if (df_r) begin
            // Oversized with Don't Fragment: dropped.
            kind_nxt  = ipv6fp_pkg::KIND_DROP;
            total_nxt = '0;
            start_nxt = '0;
            offo_nxt  = '0;
            moreo_nxt = 1'b0;
            plen_nxt  = '0;
            icmp_nxt  = mtu_eff - ipv6fp_pkg::ICMP_MTU_ADJ;
            last_nxt  = 1'b1;
            state_nxt = ipv6fp_pkg::ST_IDLE;
          end else begin
            // First piece is cut to the aligned MTU.
            kind_nxt  = ipv6fp_pkg::KIND_FRAG;
            total_nxt = m_plan;
            start_nxt = ipv6fp_pkg::FRAG_HDR_LEN;
            offo_nxt  = off_r;
            moreo_nxt = 1'b1;
            plen_nxt  = m_plan - ipv6fp_pkg::IPV6_HDR_LEN;
            icmp_nxt  = '0;
            last_nxt  = 1'b0;
            m_nxt     = m_plan;
            pos_nxt   = m_plan;
            state_nxt = ipv6fp_pkg::ST_SPLIT;
          end
        end
      end
      ipv6fp_pkg::ST_SPLIT: begin
        if (out_free) begin
          // One later piece per step.
          load      = 1'b1;
          kind_nxt  = ipv6fp_pkg::KIND_FRAG;
          total_nxt = tot;
          start_nxt = pos_r;
          offo_nxt  = off_r + pos_r - ipv6fp_pkg::FRAG_HDR_LEN;
          moreo_nxt = fin ? mf_r : 1'b1;
          plen_nxt  = tot - ipv6fp_pkg::IPV6_HDR_LEN;
          icmp_nxt  = '0;
          last_nxt  = fin;
          pos_nxt   = pos_r + sz;
          if (fin) begin
            state_nxt = ipv6fp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ipv6fp_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipv6fp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    pos_r   <= pos_nxt;
    kind_r  <= kind_nxt;
    total_r <= total_nxt;
    start_r <= start_nxt;
    offo_r  <= offo_nxt;
    moreo_r <= moreo_nxt;
    plen_r  <= plen_nxt;
    icmp_r  <= icmp_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_piece_kind       = 2'(kind_r);
  assign out_piece_total_len  = total_r;
  assign out_data_start       = start_r;
  assign out_offset_out       = offo_r;
  assign out_more_out         = moreo_r;
  assign out_ipv6_payload_len = plen_r;
  assign out_icmp_mtu         = icmp_r;
  assign out_last             = last_r;

  // Whole and dropped packets give exactly one result.
  `IPV6FP_ASSERT_NOW(a_single_is_last,
    out_valid_r && (kind_r != ipv6fp_pkg::KIND_FRAG), last_r,
    "whole or dropped result not marked last")

  // A dropped result carries no length but a frag-needed MTU.
  `IPV6FP_ASSERT_NOW(a_drop_fields,
    out_valid_r && (kind_r == ipv6fp_pkg::KIND_DROP),
    (total_r == '0) && (icmp_r != '0),
    "dropped result fields inconsistent")

  // Fragment pieces stay between one header and the aligned MTU.
  `IPV6FP_ASSERT_NOW(a_frag_size,
    out_valid_r && (kind_r == ipv6fp_pkg::KIND_FRAG),
    (total_r <= m_r) && (total_r >= ipv6fp_pkg::FRAG_HDR_LEN),
    "fragment piece size out of range")

  // While splitting, some input bytes are always still to be planned.
  `IPV6FP_ASSERT_NOW(a_split_progress,
    state_r == ipv6fp_pkg::ST_SPLIT, pos_r < len_r,
    "split position passed the packet end")

endmodule
